/* sv/rte_pkg.sv */
// ----------------------------------------------------------------------------
// rte_pkg
// shared types, status codes and calendar table for the rtc-to-epoch unit
// ----------------------------------------------------------------------------
`default_nettype none

package rte_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FLOATING  = 3'd1,
        ST_HALTED    = 3'd2,
        ST_FIELD     = 3'd3,
        ST_YEAR      = 3'd4
    } t_status;

    // days from 1970-01-01 to 2000-03-01, minus one for the day-of-month offset
    localparam logic [15:0] DAYS_BASE    = 16'd11016;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [11:0] YEAR_BASE    = 12'd2000;
    localparam logic [7:0]  YY_MIN       = 8'd24;
    localparam logic [7:0]  YY_MAX       = 8'd89;

    typedef struct packed {
        t_status     status;
        logic [11:0] full_year;
        logic [3:0]  month_num;
        logic [4:0]  day_num;
        logic [4:0]  hour_num;
        logic [5:0]  minute_num;
        logic [5:0]  second_num;
    } t_fields;

    // days from march 1 to the first of the month, year starting in march
    function automatic logic [8:0] month_offset(input logic [3:0] mon);
        logic [8:0] off;
        unique case (mon)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    // nibble-wise bcd decode, digits above nine taken at face value
    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        return 8'(8'(b[7:4]) * 8'd10 + 8'(b[3:0]));
    endfunction

endpackage

`default_nettype wire

/* sv/rte_if.sv */
// ----------------------------------------------------------------------------
// rte_if
// valid/ready channels for raw rtc register requests and decoded results
// ----------------------------------------------------------------------------
`default_nettype none

interface rte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sec_reg;
    logic [7:0] min_reg;
    logic [7:0] hour_reg;
    logic [7:0] date_reg;
    logic [7:0] month_reg;
    logic [7:0] weekday_reg;
    logic [7:0] year_reg;

    modport source (
        output valid, sec_reg, min_reg, hour_reg, date_reg, month_reg,
               weekday_reg, year_reg,
        input  ready
    );
    modport sink (
        input  valid, sec_reg, min_reg, hour_reg, date_reg, month_reg,
               weekday_reg, year_reg,
        output ready
    );
endinterface

interface rte_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] epoch_seconds;
    logic [11:0] full_year;
    logic [3:0]  month_num;
    logic [4:0]  day_num;
    logic [4:0]  hour_num;
    logic [5:0]  minute_num;
    logic [5:0]  second_num;

    modport source (
        output valid, status, epoch_seconds, full_year, month_num, day_num,
               hour_num, minute_num, second_num,
        input  ready
    );
    modport sink (
        input  valid, status, epoch_seconds, full_year, month_num, day_num,
               hour_num, minute_num, second_num,
        output ready
    );
endinterface

`default_nettype wire

/* sv/rtc_registers_to_epoch_unit.sv */
// ----------------------------------------------------------------------------
// rtc_registers_to_epoch_unit
// a result passes through four register stages (decode, day count, day
// seconds, output) between the request accept and the result
// throughput: one request per cycle while the output accepts results
// stalls back up stage by stage; a stage holds while it is full and the next one cannot move on
// reset clears all stage valid bits, payload registers are not reset
// checks raw bcd rtc registers and converts them to utc epoch seconds
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_registers_to_epoch_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rte_in_if.sink     i_in,
    rte_out_if.source  o_out
);
    import rte_pkg::*;

    // stage enables
    logic en1, en2, en3, en4;

    // stage 1: decode and check
    logic    r_s1_valid;
    t_fields r_s1_f,   n_s1_f;
    logic [6:0] r_s1_yoe, n_s1_yoe;

    logic [7:0] sec_v, min_v, hour_v, date_v, mon_v, yy_v, h12_v;
    logic       floating;

    // stage 2: day count and time of day
    logic        r_s2_valid;
    t_fields     r_s2_f;
    logic [15:0] r_s2_days, n_s2_days;
    logic [16:0] r_s2_tod,  n_s2_tod;

    // stage 3: day seconds
    logic        r_s3_valid;
    t_fields     r_s3_f;
    logic [31:0] r_s3_prod;
    logic [16:0] r_s3_tod;

    // stage 4: output register
    logic        r_s4_valid;
    t_fields     r_s4_f;
    logic [31:0] r_s4_epoch, n_s4_epoch;

    assign en4 = !r_s4_valid || o_out.ready;
    assign en3 = !r_s3_valid || en4;
    assign en2 = !r_s2_valid || en3;
    assign en1 = !r_s1_valid || en2;
    assign i_in.ready = en1;

    always_comb begin
        floating = (i_in.sec_reg == 8'hFF && i_in.min_reg == 8'hFF &&
                    i_in.hour_reg == 8'hFF && i_in.date_reg == 8'hFF &&
                    i_in.month_reg == 8'hFF && i_in.weekday_reg == 8'hFF &&
                    i_in.year_reg == 8'hFF) ||
                   (i_in.sec_reg == 8'h00 && i_in.min_reg == 8'h00 &&
                    i_in.hour_reg == 8'h00 && i_in.date_reg == 8'h00 &&
                    i_in.month_reg == 8'h00 && i_in.weekday_reg == 8'h00 &&
                    i_in.year_reg == 8'h00);
        sec_v  = bcd_value({1'b0, i_in.sec_reg[6:0]});
        min_v  = bcd_value({1'b0, i_in.min_reg[6:0]});
        date_v = bcd_value({2'b0, i_in.date_reg[5:0]});
        mon_v  = bcd_value({3'b0, i_in.month_reg[4:0]});
        yy_v   = bcd_value(i_in.year_reg);
        h12_v  = bcd_value({3'b0, i_in.hour_reg[4:0]});
        if (i_in.hour_reg[7]) begin
            // hour mod 12, decoded hour reaches 25 with digits above nine
            hour_v = ((h12_v >= 8'd24) ? h12_v - 8'd24 :
                      (h12_v >= 8'd12) ? h12_v - 8'd12 : h12_v) +
                     (i_in.hour_reg[5] ? 8'd12 : 8'd0);
        end else begin
            hour_v = bcd_value({2'b0, i_in.hour_reg[5:0]});
        end

        n_s1_f   = '0;
        n_s1_yoe = '0;
        priority if (floating) begin
            n_s1_f.status = ST_FLOATING;
        end else if (i_in.sec_reg[7]) begin
            n_s1_f.status = ST_HALTED;
        end else if (sec_v > 8'd59 || min_v > 8'd59 || hour_v > 8'd23 ||
                     date_v < 8'd1 || date_v > 8'd31 ||
                     mon_v < 8'd1 || mon_v > 8'd12) begin
            n_s1_f.status = ST_FIELD;
        end else if (yy_v < YY_MIN || yy_v > YY_MAX) begin
            n_s1_f.status = ST_YEAR;
        end else begin
            n_s1_f.status     = ST_OK;
            n_s1_f.full_year  = YEAR_BASE + 12'(yy_v);
            n_s1_f.month_num  = mon_v[3:0];
            n_s1_f.day_num    = date_v[4:0];
            n_s1_f.hour_num   = hour_v[4:0];
            n_s1_f.minute_num = min_v[5:0];
            n_s1_f.second_num = sec_v[5:0];
            // year of era counted from 2000, march-based
            n_s1_yoe = 7'(yy_v - ((mon_v <= 8'd2) ? 8'd1 : 8'd0));
        end
    end

    always_comb begin
        n_s2_days = DAYS_BASE + 16'(r_s1_yoe) * 16'd365 + 16'(r_s1_yoe[6:2]) +
                    16'(month_offset(r_s1_f.month_num)) + 16'(r_s1_f.day_num);
        n_s2_tod  = 17'(r_s1_f.hour_num) * 17'd3600 +
                    17'(r_s1_f.minute_num) * 17'd60 + 17'(r_s1_f.second_num);
    end

    always_comb begin
        n_s4_epoch = (r_s3_f.status == ST_OK) ? r_s3_prod + 32'(r_s3_tod) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (en1) r_s1_valid <= i_in.valid;
            if (en2) r_s2_valid <= r_s1_valid;
            if (en3) r_s3_valid <= r_s2_valid;
            if (en4) r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in.valid) begin
            r_s1_f   <= n_s1_f;
            r_s1_yoe <= n_s1_yoe;
        end
        if (en2 && r_s1_valid) begin
            r_s2_f    <= r_s1_f;
            r_s2_days <= n_s2_days;
            r_s2_tod  <= n_s2_tod;
        end
        if (en3 && r_s2_valid) begin
            r_s3_f    <= r_s2_f;
            r_s3_prod <= 32'(33'(r_s2_days) * 33'(SECS_PER_DAY));
            r_s3_tod  <= r_s2_tod;
        end
        if (en4 && r_s3_valid) begin
            r_s4_f     <= r_s3_f;
            r_s4_epoch <= n_s4_epoch;
        end
    end

    assign o_out.valid         = r_s4_valid;
    assign o_out.status        = r_s4_f.status;
    assign o_out.epoch_seconds = r_s4_epoch;
    assign o_out.full_year     = r_s4_f.full_year;
    assign o_out.month_num     = r_s4_f.month_num;
    assign o_out.day_num       = r_s4_f.day_num;
    assign o_out.hour_num      = r_s4_f.hour_num;
    assign o_out.minute_num    = r_s4_f.minute_num;
    assign o_out.second_num    = r_s4_f.second_num;

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid right after reset");

    a_bad_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |->
        (o_out.epoch_seconds == 32'd0 && o_out.full_year == 12'd0 &&
         o_out.month_num == 4'd0 && o_out.day_num == 5'd0))
        else $error("fields not cleared on error status");

    a_ok_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_OK) |->
        (o_out.full_year >= 12'd2024 && o_out.full_year <= 12'd2089 &&
         o_out.month_num >= 4'd1 && o_out.month_num <= 4'd12))
        else $error("ok result with date out of range");

    a_ok_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_OK) |->
        (o_out.hour_num <= 5'd23 && o_out.minute_num <= 6'd59 &&
         o_out.second_num <= 6'd59 && o_out.epoch_seconds != 32'd0))
        else $error("ok result with time out of range");

endmodule

`default_nettype wire
